// ===== rtl/slc_pkg.sv =====
`timescale 1ns / 1ps

package slc_pkg;

    // counter width of each character class
    localparam int COUNT_WIDTH = 16;

    // fixed field widths of the channels
    localparam int CODE_W      = 16;
    localparam int LANG_W      = 3;
    localparam int SCORE_OUT_W = 19;
    localparam int TOTAL_OUT_W = 18;

    // 4*kana + han needs three bits over a counter
    localparam int SCORE_W = COUNT_WIDTH + 3;
    // internal arithmetic width, never narrower than the output fields
    localparam int WIDE_W  = (SCORE_W > SCORE_OUT_W) ? SCORE_W : SCORE_OUT_W;

    typedef enum logic [LANG_W-1:0] {
        LANG_OTHERS = 3'd0,
        LANG_ZH     = 3'd1,
        LANG_JP     = 3'd2,
        LANG_KR     = 3'd3,
        LANG_EN     = 3'd4
    } lang_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] han;
        logic [COUNT_WIDTH-1:0] kana;
        logic [COUNT_WIDTH-1:0] hangul;
        logic [COUNT_WIDTH-1:0] ascii;
    } slc_counts_t;

    typedef struct packed {
        lang_t                  language;
        logic [SCORE_OUT_W-1:0] score;
        logic [TOTAL_OUT_W-1:0] total;
    } slc_verdict_t;

endpackage

// ===== rtl/slc_in_if.sv =====
`timescale 1ns / 1ps

interface slc_in_if import slc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_unit;
    logic              last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== rtl/slc_out_if.sv =====
`timescale 1ns / 1ps

interface slc_out_if import slc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LANG_W-1:0]      language;
    logic [SCORE_OUT_W-1:0] winning_score_x2;
    logic [TOTAL_OUT_W-1:0] classified_count;

    modport source (output valid, output language, output winning_score_x2,
                    output classified_count, input ready);
    modport sink   (input valid, input language, input winning_score_x2,
                    input classified_count, output ready);
endinterface

// ===== rtl/slc_decide.sv =====
`timescale 1ns / 1ps

module slc_decide import slc_pkg::*;
(
    input  slc_counts_t  counts,
    output slc_verdict_t verdict
);

    logic [WIDE_W-1:0] han_w;
    logic [WIDE_W-1:0] kana_w;
    logic [WIDE_W-1:0] hangul_w;
    logic [WIDE_W-1:0] ascii_w;
    logic [WIDE_W-1:0] zh;
    logic [WIDE_W-1:0] jp;
    logic [WIDE_W-1:0] kr;
    logic [WIDE_W-1:0] en;
    logic [WIDE_W-1:0] total;
    logic [WIDE_W-1:0] score;
    lang_t             lang;

    assign han_w    = WIDE_W'(counts.han);
    assign kana_w   = WIDE_W'(counts.kana);
    assign hangul_w = WIDE_W'(counts.hangul);
    assign ascii_w  = WIDE_W'(counts.ascii);

    // doubled scores
    assign zh    = han_w << 1;
    assign jp    = (kana_w << 2) + han_w;
    assign kr    = hangul_w << 1;
    assign en    = ascii_w << 1;
    assign total = (han_w + kana_w) + (hangul_w + ascii_w);

    always_comb
    begin
        lang  = LANG_OTHERS;
        score = '0;
        if (total == '0)
        begin
            lang  = LANG_OTHERS;
            score = '0;
        end
        else if ((han_w != '0) && (kana_w != '0) && (jp >= zh))
        begin
            // mixed han and kana with the kana-weighted score level with or above han's
            lang  = LANG_JP;
            score = jp;
        end
        else if ((zh > jp) && (zh > en) && (zh > kr))
        begin
            lang  = LANG_ZH;
            score = zh;
        end
        else if ((jp > zh) && (jp > en) && (jp > kr))
        begin
            lang  = LANG_JP;
            score = jp;
        end
        else if ((en > jp) && (en > kr) && (en > zh))
        begin
            lang  = LANG_EN;
            score = en;
        end
        else if ((kr > zh) && (kr > en) && (kr > jp))
        begin
            lang  = LANG_KR;
            score = kr;
        end
    end

    assign verdict.language = lang;
    assign verdict.score    = score[SCORE_OUT_W-1:0];
    assign verdict.total    = total[TOTAL_OUT_W-1:0];

endmodule

// ===== rtl/script_language_classifier_unit.sv =====
`timescale 1ns / 1ps

// script language classifier
//
// text_in carries a line of text, one 16-bit utf-16 code unit per beat, with
// last_unit set on the final beat of the line. each unit is sorted into han,
// kana, hangul or ascii and bumps a saturating counter of its class; other
// units count nothing. lang_out carries one beat per line, sent after the
// last unit: the language code, the doubled score of the winner and the sum
// of the four counts. the counters clear when that beat is formed.
//
// throughput: one code unit per cycle, sustained, except that a last unit waits
// while an earlier result is still held; set by the single pass of classify,
// count and decide between the class register and the result reg. the last
// unit goes into the class register, then its verdict into the result register
// (two register stages).
// reset (rst_n low, asynchronous) empties both stages and clears counters.
// when lang_out stalls, the result stays held and the class stage keeps
// taking units; only a second last unit waits until the result is taken.
module script_language_classifier_unit import slc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    slc_in_if.sink    text_in,
    slc_out_if.source lang_out
);

    typedef struct packed {
        logic han;
        logic kana;
        logic hangul;
        logic ascii;
    } slc_class_t;

    // class stage
    slc_class_t   cls_next;
    slc_class_t   cls_reg;
    logic         last_reg;
    logic         stage_valid_reg;
    logic         stage_valid_next;

    // counters
    slc_counts_t  counts_reg;
    slc_counts_t  counts_next;
    slc_counts_t  counts_bumped;

    // result stage
    slc_verdict_t verdict;
    slc_verdict_t result_reg;
    logic         out_valid_reg;
    logic         out_valid_next;

    logic         in_fire;
    logic         advance;
    logic         load_result;

    // sort the incoming unit into its class
    always_comb
    begin
        cls_next = '0;
        if ((text_in.code_unit >= 16'h4E00) && (text_in.code_unit <= 16'h9FFF))
        begin
            cls_next.han = 1'b1;
        end
        else if ((text_in.code_unit >= 16'h3040) && (text_in.code_unit <= 16'h30FF))
        begin
            // hiragana and katakana blocks are contiguous
            cls_next.kana = 1'b1;
        end
        else if ((text_in.code_unit >= 16'hAC00) && (text_in.code_unit <= 16'hD7AF))
        begin
            cls_next.hangul = 1'b1;
        end
        else if (text_in.code_unit <= 16'h007F)
        begin
            cls_next.ascii = 1'b1;
        end
    end

    // a non-last unit always moves on; a last unit needs a free result slot
    assign advance     = stage_valid_reg && (!last_reg || !out_valid_reg || lang_out.ready);
    assign load_result = advance && last_reg;
    assign text_in.ready = !stage_valid_reg || advance;
    assign in_fire     = text_in.valid && text_in.ready;

    assign stage_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cls_reg  <= cls_next;
            last_reg <= text_in.last_unit;
        end
    end

    // saturating bump of the counter picked by the class
    always_comb
    begin
        counts_bumped = counts_reg;
        if (cls_reg.han && (counts_reg.han != '1))
        begin
            counts_bumped.han = counts_reg.han + 1'b1;
        end
        if (cls_reg.kana && (counts_reg.kana != '1))
        begin
            counts_bumped.kana = counts_reg.kana + 1'b1;
        end
        if (cls_reg.hangul && (counts_reg.hangul != '1))
        begin
            counts_bumped.hangul = counts_reg.hangul + 1'b1;
        end
        if (cls_reg.ascii && (counts_reg.ascii != '1))
        begin
            counts_bumped.ascii = counts_reg.ascii + 1'b1;
        end
    end

    // the last unit is counted before the decision, then the line starts over
    always_comb
    begin
        counts_next = counts_reg;
        if (advance)
        begin
            counts_next = last_reg ? '0 : counts_bumped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
        end
    end

    slc_decide u_decide (
        .counts  (counts_bumped),
        .verdict (verdict)
    );

    // result register
    assign out_valid_next = load_result ? 1'b1 : (lang_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg <= verdict;
        end
    end

    assign lang_out.valid            = out_valid_reg;
    assign lang_out.language         = result_reg.language;
    assign lang_out.winning_score_x2 = result_reg.score;
    assign lang_out.classified_count = result_reg.total;

    // a line end leaves all counters cleared
    a_clear_after_line: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (counts_reg == '0))
        else $error("counters not cleared after line end");

    // a unit bumps at most one class
    a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> $onehot0(cls_reg))
        else $error("unit sorted into more than one class");

    // no undecided line carries a score
    a_others_no_score: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.language == LANG_OTHERS)) |->
        (result_reg.score == '0))
        else $error("score on a line with no language");

    // a held unit keeps its class and stays in the stage
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(cls_reg)))
        else $error("class stage lost a waiting unit");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !lang_out.ready) |-> !load_result)
        else $error("result overwritten while stalled");

endmodule
